>>> src/ldq_pkg.sv
// ----------------------------------------------------------------------------
// ldq_pkg: linked deque with search, shared types and constants
// Node table size, link encoding, request and response formats, memory
// write commands passed between the sequencer and the storage modules.
// ----------------------------------------------------------------------------
package ldq_pkg;

  localparam int NODES  = 256;
  localparam int IDX_W  = $clog2(NODES);
  localparam int LINK_W = IDX_W + 1;
  localparam int CNT_W  = $clog2(NODES + 1);
  localparam int VAL_W  = 32;

  localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(NODES);

  localparam logic [2:0] OP_ADD_HEAD = 3'd0;
  localparam logic [2:0] OP_ADD_TAIL = 3'd1;
  localparam logic [2:0] OP_REM_HEAD = 3'd2;
  localparam logic [2:0] OP_REM_TAIL = 3'd3;
  localparam logic [2:0] OP_REM_VAL  = 3'd4;
  localparam logic [2:0] OP_FIND     = 3'd5;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [2:0]              op;
    logic signed [VAL_W-1:0] data_value;
  } ldq_req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [CNT_W-1:0] entry_count;
  } ldq_rsp_t;

  typedef struct packed {
    logic              val_we;
    logic [IDX_W-1:0]  val_addr;
    logic [VAL_W-1:0]  val_data;
    logic              nxt_we;
    logic [IDX_W-1:0]  nxt_addr;
    logic [LINK_W-1:0] nxt_data;
    logic              prv_we;
    logic [IDX_W-1:0]  prv_addr;
    logic [LINK_W-1:0] prv_data;
  } node_wr_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] pos;
    logic [IDX_W-1:0] idx;
  } fs_push_t;

  function automatic logic link_ok(input logic [LINK_W-1:0] l);
    return l < LINK_NONE;
  endfunction

endpackage

>>> src/linked_deque_with_search_unit.sv
// Steps: an insert passes S_ADD, then S_LINK if the deque held entries, then S_DONE;
// remove head or tail passes S_UNLINK, then S_DONE. Find and remove by value walk
// the list in S_WALK; remove by value then unlinks. Throughput: one request at a time;
// the walk reads one node per cycle from the node memory, up to NODES (256) nodes.
// Reset: synchronous, clears control state and free stack valid bits at once,
// no clearing pass; node memories are not reset.
// ----------------------------------------------------------------------------
// linked_deque_with_search_unit: doubly linked deque with value search
// Sequencer over node table memories and a free stack; six request types
// each answered with a status and the entry count.
// ----------------------------------------------------------------------------
module linked_deque_with_search_unit
  import ldq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  ldq_req_t in_req,
  output logic     out_valid,
  input  logic     out_ready,
  output ldq_rsp_t out_rsp
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD,
    S_LINK,
    S_UNLINK,
    S_WALK,
    S_DONE
  } state_t;

  state_t            state_r, state_nxt;
  logic [2:0]        op_r, op_nxt;
  logic [VAL_W-1:0]  val_r, val_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [LINK_W-1:0] nb_r, nb_nxt;
  logic [LINK_W-1:0] head_r, head_nxt;
  logic [LINK_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0]  used_r, used_nxt;
  logic [CNT_W-1:0]  steps_r, steps_nxt;
  logic [1:0]        stat_r, stat_nxt;
  logic              out_valid_r, out_valid_nxt;
  ldq_rsp_t          out_rsp_r, out_rsp_nxt;

  logic [IDX_W-1:0]  rd_addr;
  node_wr_t          node_wr;
  logic [VAL_W-1:0]  rd_value;
  logic [LINK_W-1:0] rd_next;
  logic [LINK_W-1:0] rd_prev;

  logic [IDX_W-1:0]  fs_idx;
  fs_push_t          fs_push;
  logic [CNT_W-1:0]  top_full;
  logic [CNT_W-1:0]  push_full;
  logic [IDX_W-1:0]  top_pos;
  logic              in_acc;

  ldq_nodes u_nodes (
    .clk      (clk),
    .rd_addr  (rd_addr),
    .wr       (node_wr),
    .rd_value (rd_value),
    .rd_next  (rd_next),
    .rd_prev  (rd_prev)
  );

  ldq_free u_free (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_pos (top_pos),
    .rd_idx (fs_idx),
    .push   (fs_push)
  );

  assign top_full  = CNT_W'(NODES - 1) - used_r;
  assign push_full = CNT_W'(NODES) - used_r;
  assign top_pos   = top_full[IDX_W-1:0];
  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    val_nxt       = val_r;
    idx_nxt       = idx_r;
    nb_nxt        = nb_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    used_nxt      = used_r;
    steps_nxt     = steps_r;
    stat_nxt      = stat_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_rsp_nxt   = out_rsp_r;
    rd_addr       = idx_r;
    node_wr       = '0;
    fs_push       = '0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_nxt  = in_req.op;
          val_nxt = in_req.data_value;
          case (in_req.op)
            OP_ADD_HEAD, OP_ADD_TAIL: begin
              if (used_r >= CNT_W'(NODES)) begin
                stat_nxt  = ST_FULL;
                state_nxt = S_DONE;
              end else begin
                state_nxt = S_ADD;
              end
            end
            OP_REM_HEAD, OP_REM_TAIL: begin
              nb_nxt = (in_req.op == OP_REM_HEAD) ? head_r : tail_r;
              if (!link_ok(nb_nxt)) begin
                stat_nxt  = ST_MISS;
                state_nxt = S_DONE;
              end else begin
                idx_nxt   = nb_nxt[IDX_W-1:0];
                rd_addr   = nb_nxt[IDX_W-1:0];
                state_nxt = S_UNLINK;
              end
            end
            OP_REM_VAL, OP_FIND: begin
              if (!link_ok(head_r)) begin
                stat_nxt  = ST_MISS;
                state_nxt = S_DONE;
              end else begin
                idx_nxt   = head_r[IDX_W-1:0];
                rd_addr   = head_r[IDX_W-1:0];
                steps_nxt = '0;
                state_nxt = S_WALK;
              end
            end
            default: begin
              stat_nxt  = ST_OK;
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      S_ADD: begin
        idx_nxt          = fs_idx;
        node_wr.val_we   = 1'b1;
        node_wr.val_addr = fs_idx;
        node_wr.val_data = val_r;
        node_wr.nxt_we   = 1'b1;
        node_wr.nxt_addr = fs_idx;
        node_wr.prv_we   = 1'b1;
        node_wr.prv_addr = fs_idx;
        used_nxt         = used_r + CNT_W'(1);
        stat_nxt         = ST_OK;
        if (op_r == OP_ADD_HEAD) begin
          node_wr.nxt_data = head_r;
          node_wr.prv_data = LINK_NONE;
          nb_nxt           = head_r;
          head_nxt         = {1'b0, fs_idx};
          if (link_ok(head_r)) begin
            state_nxt = S_LINK;
          end else begin
            tail_nxt  = {1'b0, fs_idx};
            state_nxt = S_DONE;
          end
        end else begin
          node_wr.nxt_data = LINK_NONE;
          node_wr.prv_data = tail_r;
          nb_nxt           = tail_r;
          tail_nxt         = {1'b0, fs_idx};
          if (link_ok(tail_r)) begin
            state_nxt = S_LINK;
          end else begin
            head_nxt  = {1'b0, fs_idx};
            state_nxt = S_DONE;
          end
        end
      end

      S_LINK: begin
        if (op_r == OP_ADD_HEAD) begin
          node_wr.prv_we   = 1'b1;
          node_wr.prv_addr = nb_r[IDX_W-1:0];
          node_wr.prv_data = {1'b0, idx_r};
        end else begin
          node_wr.nxt_we   = 1'b1;
          node_wr.nxt_addr = nb_r[IDX_W-1:0];
          node_wr.nxt_data = {1'b0, idx_r};
        end
        state_nxt = S_DONE;
      end

      S_UNLINK: begin
        if (link_ok(rd_prev)) begin
          node_wr.nxt_we   = 1'b1;
          node_wr.nxt_addr = rd_prev[IDX_W-1:0];
          node_wr.nxt_data = rd_next;
        end else begin
          head_nxt = link_ok(rd_next) ? rd_next : LINK_NONE;
        end
        if (link_ok(rd_next)) begin
          node_wr.prv_we   = 1'b1;
          node_wr.prv_addr = rd_next[IDX_W-1:0];
          node_wr.prv_data = rd_prev;
        end else begin
          tail_nxt = link_ok(rd_prev) ? rd_prev : LINK_NONE;
        end
        if (used_r != '0) begin
          used_nxt    = used_r - CNT_W'(1);
          fs_push.en  = 1'b1;
          fs_push.pos = push_full[IDX_W-1:0];
          fs_push.idx = idx_r;
        end
        stat_nxt  = ST_OK;
        state_nxt = S_DONE;
      end

      S_WALK: begin
        if (rd_value == val_r) begin
          if (op_r == OP_FIND) begin
            stat_nxt  = ST_OK;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_UNLINK;
          end
        end else if (!link_ok(rd_next) || steps_r == CNT_W'(NODES - 1)) begin
          stat_nxt  = ST_MISS;
          state_nxt = S_DONE;
        end else begin
          idx_nxt   = rd_next[IDX_W-1:0];
          rd_addr   = rd_next[IDX_W-1:0];
          steps_nxt = steps_r + CNT_W'(1);
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt           = 1'b1;
          out_rsp_nxt.status      = stat_r;
          out_rsp_nxt.entry_count = used_r;
          state_nxt               = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= LINK_NONE;
      tail_r      <= LINK_NONE;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r      <= op_nxt;
    val_r     <= val_nxt;
    idx_r     <= idx_nxt;
    nb_r      <= nb_nxt;
    steps_r   <= steps_nxt;
    stat_r    <= stat_nxt;
    out_rsp_r <= out_rsp_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CNT_W'(NODES))
    else $error("entry count above table size");

  a_empty_match: assert property (@(posedge clk) disable iff (!rst_n)
    (used_r == '0) == (!link_ok(head_r) && !link_ok(tail_r)))
    else $error("head/tail links disagree with entry count");

  a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("response raised outside done state");

  a_link_after_add: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LINK) |-> $past(state_r == S_ADD))
    else $error("neighbor link write without insert");

endmodule

>>> src/ldq_nodes.sv
// ----------------------------------------------------------------------------
// ldq_nodes: node table storage
// Value, next link and prev link memories, one shared read address with
// registered read data, one write port per memory.
// ----------------------------------------------------------------------------
module ldq_nodes
  import ldq_pkg::*;
(
  input  logic              clk,
  input  logic [IDX_W-1:0]  rd_addr,
  input  node_wr_t          wr,
  output logic [VAL_W-1:0]  rd_value,
  output logic [LINK_W-1:0] rd_next,
  output logic [LINK_W-1:0] rd_prev
);

  logic [VAL_W-1:0]  value_mem [NODES];
  logic [LINK_W-1:0] next_mem  [NODES];
  logic [LINK_W-1:0] prev_mem  [NODES];

  logic [VAL_W-1:0]  rd_value_r;
  logic [LINK_W-1:0] rd_next_r;
  logic [LINK_W-1:0] rd_prev_r;

  always_ff @(posedge clk) begin
    if (wr.val_we) begin
      value_mem[wr.val_addr] <= wr.val_data;
    end
    rd_value_r <= value_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wr.nxt_we) begin
      next_mem[wr.nxt_addr] <= wr.nxt_data;
    end
    rd_next_r <= next_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wr.prv_we) begin
      prev_mem[wr.prv_addr] <= wr.prv_data;
    end
    rd_prev_r <= prev_mem[rd_addr];
  end

  assign rd_value = rd_value_r;
  assign rd_next  = rd_next_r;
  assign rd_prev  = rd_prev_r;

endmodule

>>> src/ldq_free.sv
// ----------------------------------------------------------------------------
// ldq_free: free node stack
// Stack memory with per-entry valid bits; an entry never pushed reads as
// its own position, which matches the initial contents 0 to NODES-1.
// ----------------------------------------------------------------------------
module ldq_free
  import ldq_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IDX_W-1:0] rd_pos,
  output logic [IDX_W-1:0] rd_idx,
  input  fs_push_t         push
);

  logic [IDX_W-1:0] stack_mem [NODES];
  logic [NODES-1:0] vld_r;
  logic [IDX_W-1:0] rd_idx_r;

  always_ff @(posedge clk) begin
    if (push.en) begin
      stack_mem[push.pos] <= push.idx;
    end
    rd_idx_r <= vld_r[rd_pos] ? stack_mem[rd_pos] : rd_pos;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (push.en) begin
      vld_r[push.pos] <= 1'b1;
    end
  end

  assign rd_idx = rd_idx_r;

endmodule
